/* src/firlc_pkg.sv */
// ----------------------------------------------------------------------------
// firlc_pkg
// Shared sizes, command codes, sequencer states and beat types for the
// loadable-coefficient FIR filter.
// ----------------------------------------------------------------------------
package firlc_pkg;

  localparam int MAX_TAPS    = 64;
  localparam int SAMPLE_BITS = 16;
  localparam int TAP_CNT_W   = 7;
  localparam int COEF_IDX_W  = 6;

  localparam int ADDR_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int CNT_W  = $clog2(MAX_TAPS + 1);
  localparam int NCMP_W = (CNT_W > TAP_CNT_W) ? CNT_W : TAP_CNT_W;
  localparam int PROD_W = 2 * SAMPLE_BITS;
  localparam int ACC_W  = PROD_W + $clog2(MAX_TAPS) + 1;

  localparam logic [TAP_CNT_W-1:0] TAP_CNT_RST = 7'd64;

  typedef enum logic [1:0] {
    CMD_FILTER = 2'd0,
    CMD_PUSH   = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_COEF   = 2'd3
  } firlc_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DONE
  } firlc_state_t;

  typedef struct packed {
    firlc_cmd_t                    cmd;
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic [COEF_IDX_W-1:0]         coeff_index;
    logic signed [SAMPLE_BITS-1:0] coeff_value;
  } firlc_in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] filtered;
    logic                          saturated;
  } firlc_out_t;

endpackage

/* src/fir_filter_loadable_coeffs_core.sv */
// ----------------------------------------------------------------------------
// fir_filter_loadable_coeffs_core
// Direct-form FIR filter with a loadable coefficient store and one shared
// multiply-accumulate unit.
// ----------------------------------------------------------------------------
// A push-and-filter beat (cmd 0) holds the input stalled after acceptance,
// while the single multiply-accumulate unit visits one tap per cycle, with
// taps being tap_count clamped to 1..MAX_TAPS, and then through RAM read,
// product register, drain and round/saturate. Push-only, clear-history and
// coefficient-write beats leave the input unstalled and return no result. The
// result sits in an output register, so a waiting result does not block the next
// beat until that next filter result is ready. History and coefficient
// entries carry valid bits, so reset and clear take effect at once.
// ----------------------------------------------------------------------------
module fir_filter_loadable_coeffs_core
  import firlc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  firlc_in_t            in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output firlc_out_t           out_data,
  input  logic                 cfg_we,
  input  logic [TAP_CNT_W-1:0] cfg_wdata
);

  localparam logic signed [ACC_W-1:0] OUT_MAX =
    {{(ACC_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] OUT_MIN = ~OUT_MAX;
  localparam logic signed [ACC_W-1:0] RND =
    {{(ACC_W-SAMPLE_BITS+1){1'b0}}, 1'b1, {(SAMPLE_BITS-2){1'b0}}};

  firlc_state_t state_r, state_nxt;

  logic [TAP_CNT_W-1:0] tap_count_r;
  logic [ADDR_W-1:0]    wp_r, wp_nxt, wp_inc;
  logic [CNT_W-1:0]     n_r, n_nxt, n_use;
  logic [CNT_W-1:0]     k_r, k_nxt;
  logic [ADDR_W-1:0]    idx_r, idx_nxt, start_idx;
  logic [CNT_W:0]       start_sum;
  logic [NCMP_W-1:0]    tap_ext;

  logic [MAX_TAPS-1:0]  hist_vld_r, hist_vld_nxt;
  logic [MAX_TAPS-1:0]  coef_vld_r, coef_vld_nxt;

  logic                 accept, issue, coef_wr, hist_wr;
  logic [ADDR_W-1:0]    coef_waddr;
  logic [SAMPLE_BITS-1:0] hist_rdata, coef_rdata;

  logic                 s1_vld_r, s2_vld_r, hv_r, cv_r;
  logic signed [SAMPLE_BITS-1:0] samp_op, coef_op;
  logic signed [PROD_W-1:0]      prod_r;
  logic signed [ACC_W-1:0]       acc_r, sum_rnd, shifted;
  logic                 sat_hi, sat_lo, out_free;

  logic                 out_vld_r;
  firlc_out_t           out_data_r, res_w;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign out_free = !out_vld_r || !out_stall;
  assign issue    = (state_r == ST_MAC) && (k_r < n_r);

  assign hist_wr = accept && (in_data.cmd == CMD_FILTER || in_data.cmd == CMD_PUSH);
  assign coef_wr = accept && (in_data.cmd == CMD_COEF) &&
                   (32'(in_data.coeff_index) < 32'(MAX_TAPS));
  assign coef_waddr = ADDR_W'(in_data.coeff_index);

  assign wp_inc  = (wp_r == ADDR_W'(MAX_TAPS - 1)) ? '0 : wp_r + 1'b1;
  assign tap_ext = NCMP_W'(tap_count_r);

  always_comb begin
    if (tap_ext == '0) begin
      n_use = CNT_W'(1);
    end else if (tap_ext > NCMP_W'(MAX_TAPS)) begin
      n_use = CNT_W'(MAX_TAPS);
    end else begin
      n_use = CNT_W'(tap_ext);
    end
  end

  assign start_sum = (CNT_W+1)'(wp_inc) + (CNT_W+1)'(MAX_TAPS) - (CNT_W+1)'(n_use);
  assign start_idx = (start_sum >= (CNT_W+1)'(MAX_TAPS)) ?
                     ADDR_W'(start_sum - (CNT_W+1)'(MAX_TAPS)) : ADDR_W'(start_sum);

  firlc_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_TAPS)) u_hist_ram (
    .clk     (clk),
    .wr_en   (hist_wr),
    .wr_addr (wp_r),
    .wr_data (in_data.sample_in),
    .rd_addr (idx_r),
    .rd_data (hist_rdata)
  );

  firlc_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_TAPS)) u_coef_ram (
    .clk     (clk),
    .wr_en   (coef_wr),
    .wr_addr (coef_waddr),
    .wr_data (in_data.coeff_value),
    .rd_addr (k_r[ADDR_W-1:0]),
    .rd_data (coef_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tap_count_r <= TAP_CNT_RST;
      wp_r        <= '0;
      n_r         <= '0;
      k_r         <= '0;
      idx_r       <= '0;
      hist_vld_r  <= '0;
      coef_vld_r  <= '0;
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      out_vld_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      wp_r       <= wp_nxt;
      n_r        <= n_nxt;
      k_r        <= k_nxt;
      idx_r      <= idx_nxt;
      hist_vld_r <= hist_vld_nxt;
      coef_vld_r <= coef_vld_nxt;
      s1_vld_r   <= issue;
      s2_vld_r   <= s1_vld_r;
      if (cfg_we) begin
        tap_count_r <= cfg_wdata;
      end
      if (state_r == ST_DONE && out_free) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_comb begin
    state_nxt    = state_r;
    wp_nxt       = wp_r;
    n_nxt        = n_r;
    k_nxt        = k_r;
    idx_nxt      = idx_r;
    hist_vld_nxt = hist_vld_r;
    coef_vld_nxt = coef_vld_r;
    if (coef_wr) begin
      coef_vld_nxt[coef_waddr] = 1'b1;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_data.cmd) inside
            CMD_CLEAR: begin
              hist_vld_nxt = '0;
              wp_nxt       = '0;
            end
            CMD_FILTER, CMD_PUSH: begin
              hist_vld_nxt[wp_r] = 1'b1;
              wp_nxt             = wp_inc;
              if (in_data.cmd == CMD_FILTER) begin
                n_nxt     = n_use;
                k_nxt     = '0;
                idx_nxt   = start_idx;
                state_nxt = ST_MAC;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_MAC: begin
        if (issue) begin
          k_nxt   = k_r + 1'b1;
          idx_nxt = (idx_r == ADDR_W'(MAX_TAPS - 1)) ? '0 : idx_r + 1'b1;
        end else if (!s1_vld_r && !s2_vld_r) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Multiply-accumulate pipeline: RAM read, product, accumulate.
  always_ff @(posedge clk) begin
    if (issue) begin
      hv_r <= hist_vld_r[idx_r];
      cv_r <= coef_vld_r[k_r[ADDR_W-1:0]];
    end
    if (s1_vld_r) begin
      prod_r <= samp_op * coef_op;
    end
    if (accept) begin
      acc_r <= '0;
    end else if (s2_vld_r) begin
      acc_r <= acc_r + {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
    end
  end

  assign samp_op = hv_r ? $signed(hist_rdata) : '0;
  assign coef_op = cv_r ? $signed(coef_rdata) : '0;

  assign sum_rnd = acc_r + RND;
  assign shifted = sum_rnd >>> (SAMPLE_BITS - 1);
  assign sat_hi  = shifted > OUT_MAX;
  assign sat_lo  = shifted < OUT_MIN;

  always_comb begin
    res_w.saturated = sat_hi || sat_lo;
    if (sat_hi) begin
      res_w.filtered = OUT_MAX[SAMPLE_BITS-1:0];
    end else if (sat_lo) begin
      res_w.filtered = OUT_MIN[SAMPLE_BITS-1:0];
    end else begin
      res_w.filtered = shifted[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_free) begin
      out_data_r <= res_w;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  a_filter_starts_mac: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.cmd == CMD_FILTER) |=> (state_r == ST_MAC))
    else $error("filter beat did not start the MAC sequence");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(state_r == ST_DONE))
    else $error("result raised outside the done state");

  a_tap_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MAC) |-> (k_r <= n_r))
    else $error("tap counter ran past taps in use");

  a_pipe_in_mac: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r || s2_vld_r) |-> (state_r == ST_MAC))
    else $error("MAC pipeline active outside the MAC state");

  a_done_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |-> (k_r == n_r && !s1_vld_r && !s2_vld_r))
    else $error("done state entered before the pipeline drained");

endmodule

/* src/firlc_ram.sv */
// ----------------------------------------------------------------------------
// firlc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module firlc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the loadable-coefficient FIR filter core. A
// scoreboard class keeps its own history, coefficient store and tap count,
// works out each filter result when an input beat is accepted, and checks
// every output beat in order. Plain tasks drive a directed opening, then
// random phases with different tap counts, coefficient reloads, pushes and
// clears, with random idle gaps and output stalls.
// ----------------------------------------------------------------------------

class fir_scoreboard;
  logic signed [firlc_pkg::SAMPLE_BITS-1:0] history [firlc_pkg::MAX_TAPS];
  logic signed [firlc_pkg::SAMPLE_BITS-1:0] coefs   [firlc_pkg::MAX_TAPS];
  logic [firlc_pkg::ADDR_W-1:0]             wr_pos;
  logic [firlc_pkg::TAP_CNT_W-1:0]          tap_count;
  firlc_pkg::firlc_out_t                    filtered_q[$];
  int                                       errors;

  function new();
    foreach (history[i]) history[i] = '0;
    foreach (coefs[i]) coefs[i] = '0;
    wr_pos    = '0;
    tap_count = firlc_pkg::TAP_CNT_RST;
    errors    = 0;
  endfunction

  function int taps_in_use(logic [firlc_pkg::TAP_CNT_W-1:0] t);
    if (t == 0) return 1;
    if (t > firlc_pkg::MAX_TAPS) return firlc_pkg::MAX_TAPS;
    return int'(t);
  endfunction

  function int pending();
    return filtered_q.size();
  endfunction

  function void note_beat(firlc_pkg::firlc_in_t b);
    int                    taps;
    int                    slot;
    longint                acc;
    longint                res;
    longint                maxv;
    firlc_pkg::firlc_out_t r;
    maxv = (longint'(1) <<< (firlc_pkg::SAMPLE_BITS - 1)) - 1;
    case (b.cmd)
      firlc_pkg::CMD_CLEAR: begin
        foreach (history[i]) history[i] = '0;
        wr_pos = '0;
      end
      firlc_pkg::CMD_COEF: begin
        coefs[b.coeff_index] = b.coeff_value;
      end
      default: begin
        history[wr_pos] = b.sample_in;
        wr_pos = wr_pos + 1'b1;
        if (b.cmd == firlc_pkg::CMD_FILTER) begin
          taps = taps_in_use(tap_count);
          acc  = 0;
          for (int k = 0; k < taps; k++) begin
            slot = (int'(wr_pos) + firlc_pkg::MAX_TAPS - taps + k) % firlc_pkg::MAX_TAPS;
            acc += longint'(coefs[k]) * longint'(history[slot]);
          end
          acc += longint'(1) <<< (firlc_pkg::SAMPLE_BITS - 2);
          res = acc >>> (firlc_pkg::SAMPLE_BITS - 1);
          r.saturated = 1'b0;
          if (res > maxv) begin
            res = maxv;
            r.saturated = 1'b1;
          end else if (res < -maxv - 1) begin
            res = -maxv - 1;
            r.saturated = 1'b1;
          end
          r.filtered = res[firlc_pkg::SAMPLE_BITS-1:0];
          filtered_q = {filtered_q, r};
        end
      end
    endcase
  endfunction

  function void check_result(firlc_pkg::firlc_out_t got);
    firlc_pkg::firlc_out_t want;
    if (filtered_q.size() == 0) begin
      errors++;
      $error("unexpected result beat: filtered %0d saturated %0b",
             got.filtered, got.saturated);
      return;
    end
    want = filtered_q.pop_front();
    if (got.filtered !== want.filtered) begin
      errors++;
      $error("filtered: expected %0d, got %0d", want.filtered, got.filtered);
    end
    if (got.saturated !== want.saturated) begin
      errors++;
      $error("saturated: expected %0b, got %0b", want.saturated, got.saturated);
    end
  endfunction
endclass

module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import firlc_pkg::*;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  firlc_in_t            in_data;
  logic                 out_valid;
  logic                 out_stall;
  firlc_out_t           out_data;
  logic                 cfg_we;
  logic [TAP_CNT_W-1:0] cfg_wdata;

  fir_scoreboard sb;
  bit            calm_in;
  int            beats_sent;

  fir_filter_loadable_coeffs_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] rand_q15();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h7FFF;
    if (r == 1) return 16'h8000;
    if (r == 2) return SAMPLE_BITS'($urandom_range(0, 15) - 8);
    return SAMPLE_BITS'($urandom);
  endfunction

  function automatic firlc_in_t mk_beat(firlc_cmd_t c, logic [SAMPLE_BITS-1:0] s,
                                        logic [COEF_IDX_W-1:0] idx,
                                        logic [SAMPLE_BITS-1:0] v);
    firlc_in_t b;
    b.cmd         = c;
    b.sample_in   = s;
    b.coeff_index = idx;
    b.coeff_value = v;
    return b;
  endfunction

  task automatic send_beat(firlc_in_t b);
    int gap;
    gap = pick_gap(calm_in);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_beat(b);
    beats_sent++;
  endtask

  // drop valid, wait for every result, then let any push or write settle
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (MAX_TAPS + 8) @(negedge clk);
  endtask

  task automatic write_taps(logic [TAP_CNT_W-1:0] v);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    sb.tap_count = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase();
    int                   r;
    int                   n;
    int                   len;
    logic [TAP_CNT_W-1:0] t;
    r = $urandom_range(0, 19);
    if (r == 0)      t = '0;
    else if (r == 1) t = TAP_CNT_W'(MAX_TAPS);
    else if (r == 2) t = TAP_CNT_W'($urandom_range(MAX_TAPS + 1, 127));
    else if (r == 3) t = 7'd127;
    else if (r < 7)  t = TAP_CNT_W'($urandom_range(9, MAX_TAPS - 1));
    else             t = TAP_CNT_W'($urandom_range(1, 8));
    write_taps(t);
    calm_in = ($urandom_range(0, 3) == 0);
    len = $urandom_range(40, 120);
    if ($urandom_range(0, 9) < 6) begin
      // reload the taps in use, then stream samples through them
      n = sb.taps_in_use(t);
      for (int k = 0; k < n; k++)
        send_beat(mk_beat(CMD_COEF, SAMPLE_BITS'($urandom), COEF_IDX_W'(k), rand_q15()));
      if ($urandom_range(0, 4) == 0)
        send_beat(mk_beat(CMD_CLEAR, SAMPLE_BITS'($urandom), COEF_IDX_W'($urandom),
                          SAMPLE_BITS'($urandom)));
      for (int i = 0; i < len; i++) begin
        r = $urandom_range(0, 99);
        if (r < 85)
          send_beat(mk_beat(CMD_FILTER, rand_q15(), COEF_IDX_W'($urandom),
                            SAMPLE_BITS'($urandom)));
        else if (r < 95)
          send_beat(mk_beat(CMD_PUSH, rand_q15(), COEF_IDX_W'($urandom),
                            SAMPLE_BITS'($urandom)));
        else if (r < 97)
          send_beat(mk_beat(CMD_CLEAR, rand_q15(), COEF_IDX_W'($urandom),
                            SAMPLE_BITS'($urandom)));
        else
          send_beat(mk_beat(CMD_COEF, rand_q15(), COEF_IDX_W'($urandom), rand_q15()));
      end
    end else begin
      for (int i = 0; i < len; i++) begin
        r = $urandom_range(0, 99);
        if (r < 55)
          send_beat(mk_beat(CMD_FILTER, rand_q15(), COEF_IDX_W'($urandom),
                            SAMPLE_BITS'($urandom)));
        else if (r < 75)
          send_beat(mk_beat(CMD_PUSH, rand_q15(), COEF_IDX_W'($urandom),
                            SAMPLE_BITS'($urandom)));
        else if (r < 80)
          send_beat(mk_beat(CMD_CLEAR, rand_q15(), COEF_IDX_W'($urandom),
                            SAMPLE_BITS'($urandom)));
        else
          send_beat(mk_beat(CMD_COEF, rand_q15(), COEF_IDX_W'($urandom), rand_q15()));
      end
    end
  endtask

  initial begin : rx_stall
    int run;
    int hold;
    out_stall = 1'b0;
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 20);
      repeat (run) @(negedge clk);
      hold = pick_gap(1'b0);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
      sb.check_result(out_data);
  end

  initial begin : stimulus
    sb         = new();
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    calm_in    = 1'b0;
    beats_sent = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // full window with reset coefficients, then clipping both ways
    send_beat(mk_beat(CMD_FILTER, 16'h7FFF, 6'd0, 16'h0000));
    send_beat(mk_beat(CMD_COEF, 16'h0000, 6'd63, 16'h8000));
    send_beat(mk_beat(CMD_FILTER, 16'h8000, 6'd0, 16'h0000));
    send_beat(mk_beat(CMD_COEF, 16'h0000, 6'd62, 16'h8000));
    send_beat(mk_beat(CMD_PUSH, 16'h7FFF, 6'd0, 16'h0000));
    send_beat(mk_beat(CMD_FILTER, 16'h7FFF, 6'd0, 16'h0000));
    send_beat(mk_beat(CMD_CLEAR, 16'hFFFF, 6'd63, 16'hFFFF));
    send_beat(mk_beat(CMD_FILTER, 16'h0000, 6'd0, 16'h0000));
    // ties round up
    send_beat(mk_beat(CMD_COEF, 16'h0000, 6'd63, 16'h0001));
    send_beat(mk_beat(CMD_FILTER, 16'h4000, 6'd0, 16'h0000));
    send_beat(mk_beat(CMD_CLEAR, 16'h0000, 6'd0, 16'h0000));
    send_beat(mk_beat(CMD_FILTER, 16'hC000, 6'd0, 16'h0000));
    send_beat(mk_beat(CMD_COEF, 16'h0000, 6'd0, 16'h7FFF));
    send_beat(mk_beat(CMD_COEF, 16'h0000, 6'd42, 16'h5555));
    send_beat(mk_beat(CMD_COEF, 16'h0000, 6'd21, 16'hAAAA));
    send_beat(mk_beat(CMD_FILTER, 16'h5555, 6'd0, 16'h0000));
    // zero taps act as one, oversize counts clamp to the full depth
    write_taps(7'd0);
    send_beat(mk_beat(CMD_FILTER, 16'h7FFF, 6'd0, 16'h0000));
    send_beat(mk_beat(CMD_FILTER, 16'h8000, 6'd0, 16'h0000));
    write_taps(7'd127);
    send_beat(mk_beat(CMD_FILTER, 16'h0001, 6'd0, 16'h0000));
    write_taps(7'd1);
    send_beat(mk_beat(CMD_PUSH, 16'd100, 6'd0, 16'h0000));
    send_beat(mk_beat(CMD_FILTER, 16'hFFFF, 6'd0, 16'h0000));
    write_taps(7'd65);
    send_beat(mk_beat(CMD_FILTER, 16'h7FFF, 6'd0, 16'h0000));

    while (beats_sent < 1625) run_phase();

    wait_idle();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #30_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
